// ----- rtl/shsm_pkg.sv -----
`default_nettype none

package shsm_pkg;

    localparam int HEADER_WORDS = 5;
    localparam int CMD_REGS     = 5;
    localparam int WINDOW_BYTES = HEADER_WORDS * 4;
    localparam int FILL_W       = 5;
    localparam int ADDR_W       = 5;
    localparam int CRC_BITS     = 128;

    localparam logic [7:0]  TYPE_VALUE = 8'h01;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_XOROUT = 32'hFFFFFFFF;

    localparam logic [31:0] MARKER_HIGH_RESET = 32'h52503230;
    localparam logic [31:0] MARKER_LOW_RESET  = 32'h34302121;
    localparam logic [31:0] CMD0_RESET        = 32'h44440100;
    localparam logic [31:0] CMD1_RESET        = 32'h51540100;
    localparam logic [31:0] CMD2_RESET        = 32'h43500100;
    localparam logic [31:0] CMD3_RESET        = 32'h43530100;
    localparam logic [31:0] CMD4_RESET        = 32'h43520100;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_MARKER_HIGH = 3'd0;
    localparam logic [2:0] REG_MARKER_LOW  = 3'd1;
    localparam logic [2:0] REG_CMD0        = 3'd2;
    localparam logic [2:0] REG_CMD1        = 3'd3;
    localparam logic [2:0] REG_CMD2        = 3'd4;
    localparam logic [2:0] REG_CMD3        = 3'd5;
    localparam logic [2:0] REG_CMD4        = 3'd6;

    localparam logic [2:0] LAST_BEAT = 3'(HEADER_WORDS - 1);

    typedef struct packed {
        logic [31:0]               marker_high;
        logic [31:0]               marker_low;
        logic [CMD_REGS-1:0][31:0] cmd;
    } cfg_t;

    typedef struct packed {
        logic [HEADER_WORDS-1:0][31:0] words;
        logic [2:0]                    command_index;
        logic [15:0]                   sequence_number;
        logic [7:0]                    payload_length;
    } hdr_entry_t;

    typedef logic [CRC_BITS-1:0][31:0] crc_cols_t;

    // Reflected CRC-32 over 16 bytes, byte 0 in the top bits of msg.
    function automatic logic [31:0] crc_calc(input logic [CRC_BITS-1:0] msg,
                                             input logic [31:0] init);
        logic [31:0] c;
        logic [7:0]  b;
        c = init;
        for (int k = 0; k < CRC_BITS / 8; k++) begin
            b = msg[CRC_BITS - 1 - 8 * k -: 8];
            c = c ^ {24'd0, b};
            for (int n = 0; n < 8; n++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
        end
        return c;
    endfunction

    // Contribution of each message bit; the CRC is linear over GF(2).
    function automatic crc_cols_t crc_cols_build();
        crc_cols_t r;
        for (int j = 0; j < CRC_BITS; j++) begin
            r[j] = crc_calc(CRC_BITS'(1) << j, 32'd0);
        end
        return r;
    endfunction

    localparam crc_cols_t   CRC_COLS   = crc_cols_build();
    localparam logic [31:0] CRC_AFFINE = crc_calc('0, CRC_INIT) ^ CRC_XOROUT;

endpackage

`default_nettype wire

// ----- rtl/shsm_byte_if.sv -----
`default_nettype none

interface shsm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/shsm_hdr_if.sv -----
`default_nettype none

interface shsm_hdr_if;
    logic        valid;
    logic        ready;
    logic [31:0] header_word;
    logic [2:0]  command_index;
    logic [15:0] sequence_number;
    logic [7:0]  payload_length;
    logic        last_word;

    modport source (output valid, output header_word, output command_index,
                    output sequence_number, output payload_length,
                    output last_word, input ready);
    modport sink (input valid, input header_word, input command_index,
                  input sequence_number, input payload_length,
                  input last_word, output ready);
endinterface

`default_nettype wire

// ----- rtl/shsm_front.sv -----
`default_nettype none

module shsm_front #(
    parameter int MATCH_ENTRIES = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire shsm_pkg::cfg_t     cfg,
    shsm_byte_if.sink               rx,
    input  wire logic               q_full,
    output logic                    push,
    output shsm_pkg::hdr_entry_t    push_entry
);
    import shsm_pkg::*;

    logic [HEADER_WORDS-1:0][31:0] win_reg;
    logic [HEADER_WORDS-1:0][31:0] win_next;
    logic [HEADER_WORDS-1:0][31:0] shifted;
    logic [FILL_W-1:0]             fill_reg;
    logic [FILL_W-1:0]             fill_next;
    logic [FILL_W-1:0]             fill_inc;
    logic                          accept;
    logic                          full;
    logic                          frame_ok;
    logic                          cmd_hit;
    logic [2:0]                    cmd_idx;
    logic [CRC_BITS-1:0]           crc_msg;
    logic [31:0]                   crc;
    logic [31:0]                   crc_swapped;
    logic                          hit;

    assign rx.ready = !q_full;
    assign accept   = rx.valid && rx.ready;

    // shift one byte in at word 0, carry top bytes upward
    always_comb
    begin
        shifted[0] = {win_reg[0][23:0], rx.rx_byte};
        for (int i = 1; i < HEADER_WORDS; i++) begin
            shifted[i] = {win_reg[i][23:0], win_reg[i-1][31:24]};
        end
    end

    assign fill_inc = (fill_reg < FILL_W'(WINDOW_BYTES)) ? fill_reg + 1'b1 : fill_reg;
    assign full     = (fill_inc == FILL_W'(WINDOW_BYTES));

    assign frame_ok = (shifted[0] == cfg.marker_high) && (shifted[1] == cfg.marker_low)
                      && (shifted[3][15:8] == TYPE_VALUE);

    // lowest matching entry wins
    always_comb
    begin
        cmd_hit = 1'b0;
        cmd_idx = '0;
        for (int i = MATCH_ENTRIES - 1; i >= 0; i--) begin
            if (shifted[2] == cfg.cmd[i]) begin
                cmd_hit = 1'b1;
                cmd_idx = 3'(i);
            end
        end
    end

    assign crc_msg = {shifted[3], shifted[2], shifted[1], shifted[0]};

    always_comb
    begin
        crc = CRC_AFFINE;
        for (int j = 0; j < CRC_BITS; j++) begin
            if (crc_msg[j]) begin
                crc = crc ^ CRC_COLS[j];
            end
        end
    end

    assign crc_swapped = {crc[7:0], crc[15:8], crc[23:16], crc[31:24]};
    assign hit         = full && frame_ok && cmd_hit && (crc_swapped == shifted[4]);

    assign push                       = accept && hit;
    assign push_entry.words           = shifted;
    assign push_entry.command_index   = cmd_idx;
    assign push_entry.sequence_number = {shifted[3][23:16], shifted[3][31:24]};
    assign push_entry.payload_length  = shifted[3][7:0];

    // clear the window after a matched header
    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (accept) begin
            if (hit) begin
                win_next  = '0;
                fill_next = '0;
            end else begin
                win_next  = shifted;
                fill_next = fill_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            win_reg  <= '0;
            fill_reg <= '0;
        end else begin
            win_reg  <= win_next;
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/shsm_queue.sv -----
`default_nettype none

module shsm_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire shsm_pkg::hdr_entry_t push_entry,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      pop_valid,
    output shsm_pkg::hdr_entry_t      pop_entry
);
    import shsm_pkg::*;

    hdr_entry_t mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_entry = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/shsm_back.sv -----
`default_nettype none

module shsm_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire shsm_pkg::hdr_entry_t q_entry,
    output logic                      pop,
    shsm_hdr_if.source                hdr
);
    import shsm_pkg::*;

    hdr_entry_t entry_reg;
    hdr_entry_t entry_next;
    logic       busy_reg;
    logic       busy_next;
    logic [2:0] beat_reg;
    logic [2:0] beat_next;
    logic       fire;
    logic       last;

    assign fire = hdr.valid && hdr.ready;
    assign last = (beat_reg == LAST_BEAT);
    assign pop  = q_valid && (!busy_reg || (fire && last));

    always_comb
    begin
        entry_next = entry_reg;
        busy_next  = busy_reg;
        beat_next  = beat_reg;
        if (pop) begin
            entry_next = q_entry;
            busy_next  = 1'b1;
            beat_next  = '0;
        end else if (fire) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                beat_next = beat_reg + 1'b1;
            end
        end
    end

    // oldest word first
    assign hdr.valid           = busy_reg;
    assign hdr.header_word     = entry_reg.words[LAST_BEAT - beat_reg];
    assign hdr.command_index   = entry_reg.command_index;
    assign hdr.sequence_number = entry_reg.sequence_number;
    assign hdr.payload_length  = entry_reg.payload_length;
    assign hdr.last_word       = last;

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            beat_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            beat_reg <= beat_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/serial_header_sync_matcher_unit.sv -----
// Serial header sync matcher with CRC-32 check.
// rx: one received byte per beat (valid/ready). Every byte shifts into a
// 20-byte window; once 20 bytes are in, the window is compared against the
// two marker words, the command table and the type byte, and a CRC-32 over
// the 16 newest bytes is checked against the oldest word, all in the cycle
// the byte is taken. One byte is taken per cycle while rx.ready is high.
// hdr: a matched header comes out as five beats, oldest window word first,
// each carrying command index, sequence number and length; last_word marks
// the fifth beat. The window and byte count clear after a match.
// The matched header goes into the queue and then the output stage, which
// sends its beats one per cycle while hdr.ready is high.
// A two-entry queue sits between the matcher and the output stage, so rx
// keeps flowing while hdr is stalled; rx.ready drops only when the queue
// holds two unsent headers.
// Reset (rst_n low, asynchronous) empties the window, queue and output and
// loads the register defaults. APB: registers at byte address 4*i, marker
// high, marker low, then command words 0 to 4; write them only while idle.
`default_nettype none

module serial_header_sync_matcher_unit #(
    parameter int COMMAND_ENTRIES = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [shsm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    shsm_byte_if.sink                          rx,
    shsm_hdr_if.source                         hdr
);
    import shsm_pkg::*;

    localparam int MATCH_ENTRIES = (COMMAND_ENTRIES < CMD_REGS) ? COMMAND_ENTRIES : CMD_REGS;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;
    logic       q_full;
    logic       push;
    hdr_entry_t push_entry;
    logic       pop;
    logic       q_valid;
    hdr_entry_t q_entry;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_MARKER_HIGH: cfg_next.marker_high = pwdata;
                REG_MARKER_LOW:  cfg_next.marker_low  = pwdata;
                REG_CMD0:        cfg_next.cmd[0]      = pwdata;
                REG_CMD1:        cfg_next.cmd[1]      = pwdata;
                REG_CMD2:        cfg_next.cmd[2]      = pwdata;
                REG_CMD3:        cfg_next.cmd[3]      = pwdata;
                REG_CMD4:        cfg_next.cmd[4]      = pwdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MARKER_HIGH: prdata = cfg_reg.marker_high;
            REG_MARKER_LOW:  prdata = cfg_reg.marker_low;
            REG_CMD0:        prdata = cfg_reg.cmd[0];
            REG_CMD1:        prdata = cfg_reg.cmd[1];
            REG_CMD2:        prdata = cfg_reg.cmd[2];
            REG_CMD3:        prdata = cfg_reg.cmd[3];
            REG_CMD4:        prdata = cfg_reg.cmd[4];
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.marker_high <= MARKER_HIGH_RESET;
            cfg_reg.marker_low  <= MARKER_LOW_RESET;
            cfg_reg.cmd[0]      <= CMD0_RESET;
            cfg_reg.cmd[1]      <= CMD1_RESET;
            cfg_reg.cmd[2]      <= CMD2_RESET;
            cfg_reg.cmd[3]      <= CMD3_RESET;
            cfg_reg.cmd[4]      <= CMD4_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    shsm_front #(
        .MATCH_ENTRIES (MATCH_ENTRIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .rx         (rx),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    shsm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    shsm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (pop),
        .hdr     (hdr)
    );

endmodule

`default_nettype wire

// ----- dv/serial_header_sync_matcher_unit_tb.sv -----
module serial_header_sync_matcher_unit_tb;
    import shsm_pkg::*;

    localparam int CMD_ENTRIES = 5;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 4;
    localparam int TAIL_CYCLES = 20;
    // no register behind this index; writes to it must change nothing
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    class header_scoreboard #(int ENTRIES = 5);
        typedef struct packed {
            logic [31:0] word;
            logic [2:0]  cmd_idx;
            logic [15:0] seq;
            logic [7:0]  len;
            logic        is_last;
        } beat_t;

        logic [31:0] marker_hi;
        logic [31:0] marker_lo;
        logic [31:0] cmd_word [CMD_REGS];
        logic [31:0] win [HEADER_WORDS];
        int unsigned fill;
        beat_t       hdr_q [$];
        int unsigned bytes_in;
        int unsigned beats_predicted;
        int unsigned beats_checked;
        int unsigned headers_matched;
        int unsigned mismatches;

        function new();
            marker_hi   = MARKER_HIGH_RESET;
            marker_lo   = MARKER_LOW_RESET;
            cmd_word[0] = CMD0_RESET;
            cmd_word[1] = CMD1_RESET;
            cmd_word[2] = CMD2_RESET;
            cmd_word[3] = CMD3_RESET;
            cmd_word[4] = CMD4_RESET;
            foreach (win[i])
                win[i] = '0;
            fill            = 0;
            bytes_in        = 0;
            beats_predicted = 0;
            beats_checked   = 0;
            headers_matched = 0;
            mismatches      = 0;
        endfunction

        function void note_error(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            if (idx == REG_MARKER_HIGH)
                marker_hi = v;
            else if (idx == REG_MARKER_LOW)
                marker_lo = v;
            else if (idx >= REG_CMD0 && idx <= REG_CMD4)
                cmd_word[idx - REG_CMD0] = v;
        endfunction

        function logic [31:0] reg_value(logic [2:0] idx);
            if (idx == REG_MARKER_HIGH)
                return marker_hi;
            if (idx == REG_MARKER_LOW)
                return marker_lo;
            return cmd_word[idx - REG_CMD0];
        endfunction

        // Oldest word that a good header carries: reflected CRC-32 of
        // words 3..0, top byte first, then byte-swapped.
        function logic [31:0] crc_word(logic [31:0] w3, logic [31:0] w2,
                                       logic [31:0] w1, logic [31:0] w0);
            logic [127:0] msg;
            logic [31:0]  c;
            msg = {w3, w2, w1, w0};
            c   = CRC_INIT;
            for (int k = 0; k < 16; k++)
            begin
                c = c ^ {24'd0, msg[127 - 8 * k -: 8]};
                for (int n = 0; n < 8; n++)
                    c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            c = c ^ CRC_XOROUT;
            return {c[7:0], c[15:8], c[23:16], c[31:24]};
        endfunction

        function void note_byte(logic [7:0] b);
            logic [7:0]  carry;
            logic [7:0]  top;
            logic [15:0] seq;
            int          hit;
            beat_t       e;
            bytes_in++;
            carry = b;
            for (int i = 0; i < HEADER_WORDS; i++)
            begin
                top    = win[i][31:24];
                win[i] = {win[i][23:0], carry};
                carry  = top;
            end
            if (fill < WINDOW_BYTES)
                fill++;
            if (fill < WINDOW_BYTES)
                return;
            if (win[0] != marker_hi || win[1] != marker_lo || win[3][15:8] != TYPE_VALUE)
                return;
            hit = -1;
            for (int i = 0; i < ENTRIES && i < CMD_REGS; i++)
                if (hit < 0 && win[2] == cmd_word[i])
                    hit = i;
            // only the lowest matching entry counts, even if its CRC fails
            if (hit < 0 || crc_word(win[3], win[2], win[1], win[0]) != win[4])
                return;
            seq = {win[3][23:16], win[3][31:24]};
            for (int i = 0; i < HEADER_WORDS; i++)
            begin
                e.word    = win[HEADER_WORDS - 1 - i];
                e.cmd_idx = 3'(hit);
                e.seq     = seq;
                e.len     = win[3][7:0];
                e.is_last = (i == HEADER_WORDS - 1);
                hdr_q.push_back(e);
            end
            beats_predicted += HEADER_WORDS;
            headers_matched++;
            foreach (win[i])
                win[i] = '0;
            fill = 0;
        endfunction

        function void check_beat(logic [31:0] word, logic [2:0] cmd_idx, logic [15:0] seq,
                                 logic [7:0] len, logic is_last);
            beat_t want;
            beats_checked++;
            if (hdr_q.size() == 0)
            begin
                note_error($sformatf("unexpected header beat: word %h idx %0d seq %h len %h last %b",
                                     word, cmd_idx, seq, len, is_last));
                return;
            end
            want = hdr_q.pop_front();
            if (word !== want.word || cmd_idx !== want.cmd_idx || seq !== want.seq ||
                len !== want.len || is_last !== want.is_last)
                note_error($sformatf({"header beat mismatch: expected word %h idx %0d seq %h ",
                                      "len %h last %b, got word %h idx %0d seq %h len %h last %b"},
                                     want.word, want.cmd_idx, want.seq, want.len, want.is_last,
                                     word, cmd_idx, seq, len, is_last));
        endfunction

        function int pending();
            return hdr_q.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    shsm_byte_if rx_if ();
    shsm_hdr_if  hdr_if ();

    header_scoreboard #(CMD_ENTRIES) sb;

    bit sender_idles = 1'b1;
    bit sink_idles   = 1'b1;
    int stall_left   = 0;
    int quiet_cycles = 0;

    serial_header_sync_matcher_unit #(
        .COMMAND_ENTRIES(CMD_ENTRIES)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .rx     (rx_if),
        .hdr    (hdr_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // header sink: while sink_idles is set, stall in random bursts, releasing ready between bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            hdr_if.ready <= 1'b0;
        end
        else if (sink_idles && hdr_if.ready && $urandom_range(0, 5) == 0)
        begin
            stall_left   <= $urandom_range(0, 18);
            hdr_if.ready <= 1'b0;
        end
        else
            hdr_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : monitor
        logic active;
        if (rst_n)
        begin
            active = psel;
            if (hdr_if.valid && hdr_if.ready)
            begin
                sb.check_beat(hdr_if.header_word, hdr_if.command_index, hdr_if.sequence_number,
                              hdr_if.payload_length, hdr_if.last_word);
                active = 1'b1;
            end
            if (rx_if.valid && rx_if.ready)
            begin
                sb.note_byte(rx_if.rx_byte);
                active = 1'b1;
            end
            quiet_cycles <= active ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        if (sender_idles && $urandom_range(0, 9) == 0)
        begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (rx_if.ready !== 1'b1)
            @(posedge clk);
    endtask

    // Send bytes from..upto-1 of a header built on the current markers.
    task automatic send_frame(input logic [31:0] cmd, input logic [15:0] seq,
                              input logic [7:0] len, input logic [7:0] typ,
                              input logic [31:0] crc_flip, input int from, input int upto);
        logic [31:0]  w3;
        logic [159:0] f;
        w3 = {seq[7:0], seq[15:8], typ, len};
        f  = {sb.crc_word(w3, cmd, sb.marker_lo, sb.marker_hi) ^ crc_flip,
              w3, cmd, sb.marker_lo, sb.marker_hi};
        for (int k = from; k < upto; k++)
            send_byte(f[159 - 8 * k -: 8]);
    endtask

    task automatic hold_until_drained();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        // let a byte that matched nothing settle before touching registers
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic readback_all();
        for (int i = REG_MARKER_HIGH; i <= REG_CMD4; i++)
        begin
            @(posedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {3'(i), 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            if (prdata !== sb.reg_value(3'(i)))
                sb.note_error($sformatf("register %0d read %h, expected %h",
                                        i, prdata, sb.reg_value(3'(i))));
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic configure(input int phase);
        logic [31:0] v;
        v = $urandom;
        case (phase)
            1:
            begin
                reg_write(REG_MARKER_HIGH, $urandom);
                reg_write(REG_MARKER_LOW, $urandom);
                reg_write(REG_CMD0, $urandom);
                reg_write(REG_CMD1, v);
                reg_write(REG_CMD2, $urandom);
                reg_write(REG_CMD3, v);
                reg_write(REG_CMD4, $urandom);
            end
            2:
            begin
                reg_write(REG_MARKER_HIGH, 32'h0000_0000);
                reg_write(REG_MARKER_LOW, 32'hFFFF_FFFF);
                reg_write(REG_CMD0, 32'h0000_0000);
                reg_write(REG_CMD1, 32'hFFFF_FFFF);
                reg_write(REG_CMD2, v);
                reg_write(REG_CMD3, $urandom);
                reg_write(REG_CMD4, 32'h0000_0000);
            end
            default:
            begin
                reg_write(REG_MARKER_HIGH, 32'hFFFF_FFFF);
                reg_write(REG_MARKER_LOW, 32'h0000_0000);
                reg_write(REG_CMD0, CMD0_RESET);
                reg_write(REG_CMD1, CMD1_RESET);
                reg_write(REG_CMD2, CMD2_RESET);
                reg_write(REG_CMD3, CMD3_RESET);
                reg_write(REG_CMD4, CMD4_RESET);
            end
        endcase
        reg_write(REG_UNMAPPED, $urandom);
        readback_all();
    endtask

    task automatic random_traffic(input int phase);
        int unsigned start_bytes;
        int unsigned start_beats;
        int          choice;
        logic [31:0] cmd;
        logic [31:0] flip;
        logic [15:0] seq;
        logic [7:0]  len;
        start_bytes = sb.bytes_in;
        start_beats = sb.beats_predicted;
        while (sb.bytes_in - start_bytes < 20 || sb.beats_predicted - start_beats < 5)
        begin
            if (phase < PHASES - 1)
            begin
                sender_idles = ($urandom_range(0, 3) != 0);
                sink_idles   = ($urandom_range(0, 3) != 0);
            end
            choice = $urandom_range(0, 99);
            cmd    = sb.cmd_word[$urandom_range(0, CMD_REGS - 1)];
            seq    = 16'($urandom);
            len    = 8'($urandom);
            flip   = $urandom;
            if (flip == 32'd0)
                flip = 32'd1;
            if (choice < 65)
                send_frame(cmd, seq, len, TYPE_VALUE, '0, 0, WINDOW_BYTES);
            else if (choice < 75)
                send_frame(cmd, seq, len, TYPE_VALUE, flip, 0, WINDOW_BYTES);
            else if (choice < 82)
                send_frame(cmd, seq, len, TYPE_VALUE ^ 8'($urandom_range(1, 255)), '0,
                           0, WINDOW_BYTES);
            else if (choice < 88)
                send_frame(cmd, seq, len, TYPE_VALUE, '0, 0, $urandom_range(1, WINDOW_BYTES - 1));
            else if (choice < 95)
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
            else
                send_frame($urandom, seq, len, TYPE_VALUE, '0, 0, WINDOW_BYTES);
            if ($urandom_range(0, 11) == 0)
                hold_until_drained();
        end
    endtask

    initial
    begin
        logic [15:0] seq;
        logic [31:0] w0;
        sb            = new();
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        hdr_if.ready  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        readback_all();

        // 19 bytes that would form a good header over a zero top byte: window not yet full
        seq = 16'($urandom);
        do
        begin
            seq = seq + 16'd1;
            w0  = sb.crc_word({seq[7:0], seq[15:8], TYPE_VALUE, 8'h5A}, sb.cmd_word[0],
                              sb.marker_lo, sb.marker_hi);
        end
        while (w0[31:24] != 8'h00);
        send_frame(sb.cmd_word[0], seq, 8'h5A, TYPE_VALUE, '0, 1, WINDOW_BYTES);

        send_frame(sb.cmd_word[0], 16'h0000, 8'h00, TYPE_VALUE, '0, 0, WINDOW_BYTES);
        send_frame(sb.cmd_word[1], 16'hFFFF, 8'hFF, TYPE_VALUE, '0, 0, WINDOW_BYTES);
        send_frame(sb.cmd_word[2], 16'h1234, 8'h80, TYPE_VALUE, '0, 0, WINDOW_BYTES);
        // CRC miss keeps the window; the next header still has to land
        send_frame(sb.cmd_word[3], 16'h00FF, 8'h01, TYPE_VALUE, 32'h0000_0001, 0, WINDOW_BYTES);
        send_frame(sb.cmd_word[3], 16'h00FF, 8'h01, TYPE_VALUE, '0, 0, WINDOW_BYTES);
        send_frame(sb.cmd_word[4], 16'hFF00, 8'h7F, 8'h00, '0, 0, WINDOW_BYTES);
        send_frame(sb.cmd_word[4], 16'hFF00, 8'h7F, TYPE_VALUE, '0, 0, WINDOW_BYTES);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_frame(sb.cmd_word[0], 16'hA5A5, 8'h33, TYPE_VALUE, '0, 0, 10);
        send_frame(sb.cmd_word[1], 16'hA5A5, 8'h33, TYPE_VALUE, '0, 0, WINDOW_BYTES);
        send_frame(~sb.cmd_word[2], 16'h5A5A, 8'hC3, TYPE_VALUE, '0, 0, WINDOW_BYTES);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                hold_until_drained();
                configure(phase);
            end
            if (phase == PHASES - 1)
            begin
                sender_idles = 1'b0;
                sink_idles   = 1'b0;
            end
            random_traffic(phase);
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.note_error($sformatf("%0d header beats never arrived", sb.pending()));
        $display("Sent %0d rx bytes over %0d register settings; %0d headers matched,",
                 sb.bytes_in, PHASES, sb.headers_matched);
        $display("%0d header beats checked, %0d mismatches", sb.beats_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/shsm_pkg.sv
rtl/shsm_byte_if.sv
rtl/shsm_hdr_if.sv
rtl/shsm_front.sv
rtl/shsm_queue.sv
rtl/shsm_back.sv
rtl/serial_header_sync_matcher_unit.sv
dv/serial_header_sync_matcher_unit_tb.sv
